// File: hw/rtl/pstd_pkg.sv
// Package for the percent swing turn detector.
// Holds field widths, reset constants and the structs shared by the modules.
// No dependencies.
package pstd_pkg;

	localparam int FIELD_BITS = 32;
	localparam int DAY_BITS = 32;
	localparam int PCT_BITS = 7;
	localparam int PRICE_BITS_DEF = 32;
	localparam logic [PCT_BITS-1:0] PCT_RESET = 7'd10;
	localparam logic [PCT_BITS-1:0] PCT_MIN = 7'd1;
	localparam int PCT_SCALE = 100;

	localparam logic KIND_BULL = 1'b0;
	localparam logic KIND_BEAR = 1'b1;

	typedef struct packed {
		logic rise;
		logic fall;
	} cmp_t;

	typedef struct packed {
		logic                  hit;
		logic                  kind;
		logic [DAY_BITS-1:0]   day;
		logic [FIELD_BITS-1:0] price;
		logic [DAY_BITS-1:0]   ref_day;
		logic [FIELD_BITS-1:0] ref_price;
	} turn_t;

endpackage

// File: hw/rtl/pstd_threshold.sv
// Percent threshold compare for a price against a reference price.
// Depends on pstd_pkg for the percent width and scale.
module pstd_threshold #(
	parameter int PW_BITS = pstd_pkg::PRICE_BITS_DEF
) (
	input  logic [PW_BITS-1:0]             p,
	input  logic [PW_BITS-1:0]             ref_p,
	input  logic [pstd_pkg::PCT_BITS-1:0]  pct,
	output pstd_pkg::cmp_t                 cmp
);

	localparam int WB = PW_BITS + pstd_pkg::PCT_BITS;

	logic [WB-1:0] up_scaled;
	logic [WB-1:0] dn_scaled;
	logic [WB-1:0] limit;

	always_comb begin
		up_scaled = WB'(p - ref_p) * WB'(pstd_pkg::PCT_SCALE);
		dn_scaled = WB'(ref_p - p) * WB'(pstd_pkg::PCT_SCALE);
		limit     = WB'(ref_p) * WB'(pct);
		cmp.rise  = (p >= ref_p) && (up_scaled >= limit);
		cmp.fall  = (p <= ref_p) && (dn_scaled >= limit);
	end

endmodule

// File: hw/rtl/pstd_tracker.sv
// Trend state and turn decision for the percent swing turn detector.
// Depends on pstd_pkg and instantiates pstd_threshold.
module pstd_tracker #(
	parameter int PRICE_BITS = pstd_pkg::PRICE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              series_start,
	input  logic [pstd_pkg::FIELD_BITS-1:0]   price,
	input  logic [pstd_pkg::DAY_BITS-1:0]     day_code,
	input  logic [pstd_pkg::PCT_BITS-1:0]     swing_percent,
	output pstd_pkg::turn_t                   turn
);

	localparam int PW = (PRICE_BITS < pstd_pkg::FIELD_BITS) ? PRICE_BITS : pstd_pkg::FIELD_BITS;

	logic                            active_q;
	logic                            first_q;
	logic                            rising_q;
	logic [PW-1:0]                   ext_price_q;
	logic [pstd_pkg::DAY_BITS-1:0]   ext_day_q;

	logic                            fresh;
	logic [PW-1:0]                   p;
	logic [PW-1:0]                   ref_p;
	logic [pstd_pkg::DAY_BITS-1:0]   ref_d;
	logic                            first_cur;
	logic                            rising_cur;
	logic [pstd_pkg::PCT_BITS-1:0]   pct_eff;
	pstd_pkg::cmp_t                  cmp;

	logic                            first_n;
	logic                            rising_n;
	logic [PW-1:0]                   ext_price_n;
	logic [pstd_pkg::DAY_BITS-1:0]   ext_day_n;
	logic                            hit;
	logic                            kind;

	assign p = price[PW-1:0];
	assign fresh = series_start || !active_q;
	assign ref_p = fresh ? p : ext_price_q;
	assign ref_d = fresh ? day_code : ext_day_q;
	assign first_cur = fresh ? 1'b0 : first_q;
	assign rising_cur = fresh ? 1'b1 : rising_q;
	assign pct_eff = (swing_percent == '0) ? pstd_pkg::PCT_MIN : swing_percent;

	pstd_threshold #(
		.PW_BITS (PW)
	) u_threshold (
		.p     (p),
		.ref_p (ref_p),
		.pct   (pct_eff),
		.cmp   (cmp)
	);

	always_comb begin
		first_n     = first_cur;
		rising_n    = rising_cur;
		ext_price_n = ref_p;
		ext_day_n   = ref_d;
		hit         = 1'b0;
		kind        = pstd_pkg::KIND_BULL;
		priority if (!first_cur) begin
			hit  = cmp.rise || cmp.fall;
			kind = cmp.rise ? pstd_pkg::KIND_BULL : pstd_pkg::KIND_BEAR;
			if (hit) begin
				first_n     = 1'b1;
				rising_n    = cmp.rise;
				ext_price_n = p;
				ext_day_n   = day_code;
			end
		end else if (!rising_cur) begin
			hit  = cmp.rise;
			kind = pstd_pkg::KIND_BULL;
			if (hit) begin
				rising_n    = 1'b1;
				ext_price_n = p;
				ext_day_n   = day_code;
			end else if (p < ref_p) begin
				ext_price_n = p;
				ext_day_n   = day_code;
			end
		end else begin
			hit  = cmp.fall;
			kind = pstd_pkg::KIND_BEAR;
			if (hit) begin
				rising_n    = 1'b0;
				ext_price_n = p;
				ext_day_n   = day_code;
			end else if (p > ref_p) begin
				ext_price_n = p;
				ext_day_n   = day_code;
			end
		end
	end

	always_comb begin
		turn.hit       = hit;
		turn.kind      = kind;
		turn.day       = day_code;
		turn.price     = pstd_pkg::FIELD_BITS'(p);
		turn.ref_day   = ref_d;
		turn.ref_price = pstd_pkg::FIELD_BITS'(ref_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			first_q     <= 1'b0;
			rising_q    <= 1'b1;
			ext_price_q <= '0;
			ext_day_q   <= '0;
		end else if (fire) begin
			active_q    <= 1'b1;
			first_q     <= first_n;
			rising_q    <= rising_n;
			ext_price_q <= ext_price_n;
			ext_day_q   <= ext_day_n;
		end
	end

endmodule

// File: hw/rtl/percent_swing_turn_detector.sv
// Percent swing turn detector: input register, trend tracker, result register.
// A turn word goes from the input register through the trend tracker into the result register.
// Takes one sample per cycle unless in_stall holds it while a turn waits on a stalled output word.
// Reset: asynchronous, active low; clears the series state and both valid flags,
// and sets the swing percent register to 10. Depends on pstd_pkg and pstd_tracker.
module percent_swing_turn_detector #(
	parameter int PRICE_BITS = pstd_pkg::PRICE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pstd_pkg::PCT_BITS-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              series_start,
	input  logic [pstd_pkg::FIELD_BITS-1:0]   price,
	input  logic [pstd_pkg::DAY_BITS-1:0]     day_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              turn_kind,
	output logic [pstd_pkg::DAY_BITS-1:0]     turn_day,
	output logic [pstd_pkg::FIELD_BITS-1:0]   turn_price,
	output logic [pstd_pkg::DAY_BITS-1:0]     ref_day,
	output logic [pstd_pkg::FIELD_BITS-1:0]   ref_price
);

	logic [pstd_pkg::PCT_BITS-1:0]   pct_q;
	logic                            valid_s1;
	logic                            start_s1;
	logic [pstd_pkg::FIELD_BITS-1:0] price_s1;
	logic [pstd_pkg::DAY_BITS-1:0]   day_s1;
	logic                            out_valid_q;
	pstd_pkg::turn_t                 turn;
	pstd_pkg::turn_t                 turn_q;
	logic                            advance;
	logic                            in_take;

	assign advance = valid_s1 && (!out_valid_q || !out_stall || !turn.hit);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= pstd_pkg::PCT_RESET;
		end else if (cfg_wr_en) begin
			pct_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= series_start;
			price_s1 <= price;
			day_s1   <= day_code;
		end
	end

	pstd_tracker #(
		.PRICE_BITS (PRICE_BITS)
	) u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.series_start  (start_s1),
		.price         (price_s1),
		.day_code      (day_s1),
		.swing_percent (pct_q),
		.turn          (turn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && turn.hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && turn.hit) begin
			turn_q <= turn;
		end
	end

	assign out_valid  = out_valid_q;
	assign turn_kind  = turn_q.kind;
	assign turn_day   = turn_q.day;
	assign turn_price = turn_q.price;
	assign ref_day    = turn_q.ref_day;
	assign ref_price  = turn_q.ref_price;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("Input stalled with no word held in the input register.");

	a_turn_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && turn.hit) |=> out_valid)
		else $error("A detected turn did not reach the output register.");

	a_blocked_turn_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && turn.hit && out_valid_q && out_stall) |-> (in_stall && !advance))
		else $error("A turn advanced while the output word was stalled.");

endmodule
